@@ rtl/lmtt_pkg.sv @@
// Shared codes, constants and controller/datapath interface types for the timer table.
package lmtt_pkg;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [2:0] KIND_FIRED    = 3'd0;
  localparam logic [2:0] KIND_DONE     = 3'd1;
  localparam logic [2:0] KIND_FULL     = 3'd2;
  localparam logic [2:0] KIND_NOTFOUND = 3'd3;
  localparam logic [2:0] KIND_REPORT   = 3'd4;

  localparam logic [31:0] NO_DEADLINE = 32'd2000000000;

  typedef struct packed {
    logic       latch;
    logic       tick_lazy;
    logic       tick_start;
    logic       add;
    logic       clear;
    logic       ptr_top;
    logic       ptr_zero;
    logic       ptr_qry;
    logic       ptr_inc;
    logic       walk_step;
    logic       remove_del;
    logic       emit;
    logic [2:0] kind;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       tick_pos;
    logic       cnt_zero;
    logic       full;
    logic       qry_out;
    logic       id_match;
    logic       ptr_zero;
    logic       ptr_end;
    logic       fire;
    logic       pend_v;
    logic       out_free;
  } stat_t;

endpackage

@@ rtl/lmtt_ctrl.sv @@
// Controller state machine that sequences each request through the timer table datapath.
module lmtt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output lmtt_pkg::cmd_t cmd,
  input  lmtt_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RESP, S_QRY, S_SRCH, S_WALK, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        kind_nxt  = lmtt_pkg::KIND_DONE;
        case (stat.op)
          lmtt_pkg::OP_TICK: begin
            if (stat.tick_pos) begin
              cmd.tick_lazy = 1'b1;
            end else begin
              cmd.tick_start = 1'b1;
              cmd.ptr_top    = 1'b1;
              state_nxt      = stat.cnt_zero ? S_FIN : S_WALK;
            end
          end
          lmtt_pkg::OP_ADD: begin
            if (stat.full) begin
              kind_nxt = lmtt_pkg::KIND_FULL;
            end else begin
              cmd.add = 1'b1;
            end
          end
          lmtt_pkg::OP_REMOVE: begin
            if (stat.cnt_zero) begin
              kind_nxt = lmtt_pkg::KIND_NOTFOUND;
            end else begin
              cmd.ptr_zero = 1'b1;
              state_nxt    = S_SRCH;
            end
          end
          lmtt_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          lmtt_pkg::OP_QUERY: begin
            if (stat.qry_out) begin
              kind_nxt = lmtt_pkg::KIND_NOTFOUND;
            end else begin
              cmd.ptr_qry = 1'b1;
              state_nxt   = S_QRY;
            end
          end
          default: begin
            kind_nxt = lmtt_pkg::KIND_DONE;
          end
        endcase
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = kind_r;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_QRY: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = lmtt_pkg::KIND_REPORT;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: begin
        if (stat.id_match) begin
          cmd.remove_del = 1'b1;
          kind_nxt       = lmtt_pkg::KIND_DONE;
          state_nxt      = S_RESP;
        end else if (stat.ptr_end) begin
          kind_nxt  = lmtt_pkg::KIND_NOTFOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_WALK: begin
        // A new expiry pushes the held one out, so it must wait for room at the output.
        if (!(stat.fire && stat.pend_v && !stat.out_free)) begin
          cmd.walk_step = 1'b1;
          cmd.emit      = stat.fire && stat.pend_v;
          cmd.kind      = lmtt_pkg::KIND_FIRED;
          if (stat.ptr_zero) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = stat.pend_v ? lmtt_pkg::KIND_FIRED : lmtt_pkg::KIND_DONE;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= lmtt_pkg::KIND_DONE;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

@@ rtl/lmtt_dp.sv @@
// Datapath holding the timer table, deadline and accumulator registers and the output register.
module lmtt_dp #(
  parameter int TIMER_SLOTS = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lmtt_pkg::cmd_t        cmd,
  output lmtt_pkg::stat_t       stat,
  input  logic [2:0]            in_operation,
  input  logic [31:0]           in_elapsed_ticks,
  input  logic [15:0]           in_timer_id,
  input  logic [30:0]           in_reload_delay,
  input  logic                  in_repeat_flag,
  input  logic [3:0]            in_slot_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_result_kind,
  output logic [15:0]           out_fired_id,
  output logic signed [31:0]    out_time_remaining,
  output logic                  out_last
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  logic [ID_BITS-1:0] id_r  [TIMER_SLOTS];
  logic [30:0]        rel_r [TIMER_SLOTS];
  logic [31:0]        rem_r [TIMER_SLOTS];
  logic               rep_r [TIMER_SLOTS];

  logic [CW-1:0]      cnt_r;
  logic [31:0]        nd_r, acc_r, sub_r, el_r;
  logic [IW-1:0]      ptr_r;
  logic [2:0]         op_r;
  logic [ID_BITS-1:0] tid_r, pend_id_r;
  logic [30:0]        dly_r;
  logic               rpt_r, pend_v_r;
  logic [3:0]         qidx_r;

  logic [ID_BITS-1:0] rd_id;
  logic [30:0]        rd_rel;
  logic [31:0]        rd_rem;
  logic               rd_rep;
  logic [31:0]        nd_dec, rem_new, cand, dly_ext;
  logic               fire, cand_less, del, out_free;
  logic [CW-1:0]      cnt_m1;
  logic [ID_BITS+15:0] in_id_w, pend_id_w;
  logic [IW+3:0]      qidx_w;

  assign rd_id  = id_r[ptr_r];
  assign rd_rel = rel_r[ptr_r];
  assign rd_rem = rem_r[ptr_r];
  assign rd_rep = rep_r[ptr_r];

  assign in_id_w   = {ID_BITS'(0), in_timer_id};
  assign pend_id_w = {16'd0, pend_id_r};
  assign qidx_w    = {IW'(0), qidx_r};
  assign dly_ext   = {1'b0, dly_r};

  assign nd_dec    = nd_r - el_r;
  assign rem_new   = rd_rem - sub_r;
  assign fire      = !((rem_new != 32'd0) && !rem_new[31]);
  assign cand      = fire ? {1'b0, rd_rel} : rem_new;
  assign cand_less = $signed(cand) < $signed(nd_r);
  assign cnt_m1    = cnt_r - CW'(1);
  assign del       = cmd.remove_del || (cmd.walk_step && fire && !rd_rep);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    stat          = '0;
    stat.op       = op_r;
    stat.tick_pos = (nd_dec != 32'd0) && !nd_dec[31];
    stat.cnt_zero = (cnt_r == '0);
    stat.full     = (cnt_r >= CW'(TIMER_SLOTS));
    stat.qry_out  = ((CW + 4)'(qidx_r) >= (CW + 4)'(cnt_r));
    stat.id_match = (rd_id == tid_r);
    stat.ptr_zero = (ptr_r == '0);
    stat.ptr_end  = (CW'(ptr_r) == cnt_m1);
    stat.fire     = fire;
    stat.pend_v   = pend_v_r;
    stat.out_free = out_free;
  end

  // Table storage: append, in-place update, and compaction that pulls younger entries down.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      id_r[cnt_r[IW-1:0]]  <= tid_r;
      rel_r[cnt_r[IW-1:0]] <= dly_r;
      rem_r[cnt_r[IW-1:0]] <= dly_ext;
      rep_r[cnt_r[IW-1:0]] <= rpt_r;
    end
    if (cmd.walk_step && !del) begin
      rem_r[ptr_r] <= cand;
    end
    if (del) begin
      for (int j = 0; j < TIMER_SLOTS - 1; j++) begin
        if (j >= int'(ptr_r)) begin
          id_r[j]  <= id_r[j+1];
          rel_r[j] <= rel_r[j+1];
          rem_r[j] <= rem_r[j+1];
          rep_r[j] <= rep_r[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_operation;
      el_r   <= in_elapsed_ticks;
      tid_r  <= in_id_w[ID_BITS-1:0];
      dly_r  <= in_reload_delay;
      rpt_r  <= in_repeat_flag;
      qidx_r <= in_slot_index;
    end
    if (cmd.tick_start) begin
      sub_r <= el_r + acc_r;
    end
    if (cmd.walk_step && fire) begin
      pend_id_r <= rd_id;
    end
    if (cmd.ptr_top) begin
      ptr_r <= cnt_m1[IW-1:0];
    end else if (cmd.ptr_zero) begin
      ptr_r <= '0;
    end else if (cmd.ptr_qry) begin
      ptr_r <= qidx_w[IW-1:0];
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + IW'(1);
    end else if (cmd.walk_step && (ptr_r != '0)) begin
      ptr_r <= ptr_r - IW'(1);
    end
    if (cmd.emit) begin
      out_result_kind    <= cmd.kind;
      out_last           <= cmd.last;
      out_fired_id       <= (cmd.kind == lmtt_pkg::KIND_FIRED) ? pend_id_w[15:0] : 16'd0;
      out_time_remaining <= (cmd.kind == lmtt_pkg::KIND_REPORT) ? (rd_rem - acc_r) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      nd_r      <= lmtt_pkg::NO_DEADLINE;
      acc_r     <= '0;
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.add) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (del) begin
        cnt_r <= cnt_m1;
      end

      if (cmd.tick_lazy) begin
        nd_r  <= nd_dec;
        acc_r <= acc_r + el_r;
      end else if (cmd.tick_start || cmd.clear) begin
        nd_r  <= lmtt_pkg::NO_DEADLINE;
        acc_r <= '0;
      end else if (cmd.add) begin
        if (nd_r == lmtt_pkg::NO_DEADLINE) begin
          nd_r  <= dly_ext;
          acc_r <= '0;
        end else if (dly_ext < nd_r) begin
          nd_r <= dly_ext;
        end
      end else if (cmd.walk_step && (!fire || rd_rep) && cand_less) begin
        nd_r <= cand;
      end

      if (cmd.tick_start) begin
        pend_v_r <= 1'b0;
      end else if (cmd.walk_step && fire) begin
        pend_v_r <= 1'b1;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/lazy_multi_timer_table_core.sv @@
// Top level of the timer table with a lazily updated shared deadline.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   operation, elapsed, id, delay, repeat, slot
//   out_     output     out_valid / out_stall kind, fired id, time remaining, last
//
// Most requests pass from acceptance to a loaded result through accept, execute and emit.
// A remove searches the table one slot a cycle from the oldest entry.
// A tick that reaches the deadline walks the table one slot a cycle, newest first, unless
// a second expiry waits for the output; the single table read port sets that rate.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled output holds the walk only when a second expiry needs the output register.
module lazy_multi_timer_table_core #(
  parameter int TIMER_SLOTS = 16,
  parameter int ID_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [31:0]        in_elapsed_ticks,
  input  logic [15:0]        in_timer_id,
  input  logic [30:0]        in_reload_delay,
  input  logic               in_repeat_flag,
  input  logic [3:0]         in_slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_result_kind,
  output logic [15:0]        out_fired_id,
  output logic signed [31:0] out_time_remaining,
  output logic               out_last
);

  lmtt_pkg::cmd_t  cmd;
  lmtt_pkg::stat_t stat;

  lmtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  lmtt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_elapsed_ticks   (in_elapsed_ticks),
    .in_timer_id        (in_timer_id),
    .in_reload_delay    (in_reload_delay),
    .in_repeat_flag     (in_repeat_flag),
    .in_slot_index      (in_slot_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_fired_id       (out_fired_id),
    .out_time_remaining (out_time_remaining),
    .out_last           (out_last)
  );

  // Once a request is taken, no further request may enter until it has been answered.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous request still in progress");

  a_fired_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != lmtt_pkg::KIND_FIRED)) |-> (out_fired_id == 16'd0))
    else $error("non-fired result carries an id");

  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != lmtt_pkg::KIND_REPORT)) |-> (out_time_remaining == 32'sd0))
    else $error("non-report result carries a time");

  // A result may only be emitted by the walk while a held expiry exists.
  a_walk_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.walk_step) |-> (stat.pend_v && stat.fire))
    else $error("walk emitted a result without a held expiry");

endmodule
